/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on clk and off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/rtttl_pkg.sv */
// ----------------------------------------------------------------------------
// rtttl_pkg
// types, character codes, widths and helper functions of the ringtone parser
// ----------------------------------------------------------------------------
package rtttl_pkg;

  // serial divider sizes
  localparam int DIV_NUM_W = 18;
  localparam int DIV_DEN_W = 16;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  localparam int HZ_W = 20;
  localparam int MS_W = 19;

  // 60 s * 1000 ms * 4 beats per whole note
  localparam logic [DIV_NUM_W-1:0] WHOLE_NOTE_BASE = 18'd240000;
  localparam logic [7:0]           FOLD_CASE       = 8'h20;
  localparam logic [15:0]          ACC_MAX         = 16'hffff;

  localparam logic [15:0] RST_DEF_DURATION = 16'd4;
  localparam logic [3:0]  RST_DEF_OCTAVE   = 4'd6;
  localparam logic [15:0] RST_BPM          = 16'd63;
  localparam logic [3:0]  BASE_OCTAVE      = 4'd4;

  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_SHARP = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_O     = 8'h6f;

  // outcome of one parse pass over the held character
  typedef struct packed {
    logic emit;       // a note ends here
    logic again;      // same character is parsed once more
    logic wdiv;       // default section closed, whole note length needed
    logic dot_force;  // dot seen after the octave digit ends the note
  } pass_res_t;

  // note as it stands in the parser registers
  typedef struct packed {
    logic [3:0]           index;
    logic [3:0]           octave;
    logic                 rest;
    logic                 dotted;
    logic [DIV_DEN_W-1:0] dur;
    logic [DIV_NUM_W-1:0] whole_ms;
  } note_t;

  function automatic logic is_digit(input logic [7:0] ch);
    return ch inside {[CH_0:CH_9]};
  endfunction

  // acc * 10 + digit, saturating at 16 bits
  function automatic logic [15:0] sat_acc10(input logic [15:0] acc, input logic [7:0] ch);
    logic [19:0] v;
    v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {16'b0, ch[3:0]};
    return (v > {4'b0, ACC_MAX}) ? ACC_MAX : v[15:0];
  endfunction

  // octave 4 pitch table, index taken modulo 12
  function automatic logic [8:0] octave4_hz(input logic [3:0] idx);
    logic [3:0] m;
    logic [8:0] hz;
    m = (idx >= 4'd12) ? idx - 4'd12 : idx;
    case (m)
      4'd0:    hz = 9'd262;
      4'd1:    hz = 9'd277;
      4'd2:    hz = 9'd294;
      4'd3:    hz = 9'd311;
      4'd4:    hz = 9'd330;
      4'd5:    hz = 9'd349;
      4'd6:    hz = 9'd370;
      4'd7:    hz = 9'd392;
      4'd8:    hz = 9'd415;
      4'd9:    hz = 9'd440;
      4'd10:   hz = 9'd466;
      4'd11:   hz = 9'd494;
      default: hz = 9'd0;
    endcase
    return hz;
  endfunction

endpackage

/* design/ringtone_text_note_parser_core.sv */
// ----------------------------------------------------------------------------
// ringtone_text_note_parser_core
// ringtone text in, one character per transfer; note events out
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall   in_text_char, in_end_of_text
//  out_     output     out_valid/out_stall out_tone_hz, out_note_ms,
//                                          out_is_rest, out_last_of_run
//
// a character that ends no note and closes no section needs no divide; one
// that ends a note or closes the default section runs the serial divider,
// and one that ends a note and cuts off another at the end of text runs it
// twice. octave scaling runs beside the divider and ends first.
// rst_n is synchronous; after it the block takes a character at once.
// in_stall is high while a character is being worked on; a stall on the
// result side holds the last result of a character and the next character.
// ----------------------------------------------------------------------------
module ringtone_text_note_parser_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_text_char,
  input  logic                         in_end_of_text,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rtttl_pkg::HZ_W-1:0]   out_tone_hz,
  output logic [rtttl_pkg::MS_W-1:0]   out_note_ms,
  output logic                         out_is_rest,
  output logic                         out_last_of_run
);
  import rtttl_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [6:0] {
    SQ_IDLE = 7'b0000001,
    SQ_PASS = 7'b0000010,
    SQ_WDIV = 7'b0000100,
    SQ_NDIV = 7'b0001000,
    SQ_END  = 7'b0010000,
    SQ_EDIV = 7'b0100000,
    SQ_FIN  = 7'b1000000
  } seq_t;

  seq_t sq_r, sq_nxt;

  logic [7:0]      char_r;
  logic            eot_r;
  logic            again_r;
  logic            emit_dot_r;
  logic            emit_rest_r;
  logic            stage_v_r;
  logic [HZ_W-1:0] stage_hz_r;
  logic [MS_W-1:0] stage_ms_r;
  logic            stage_rest_r;
  logic            out_valid_r;
  logic [HZ_W-1:0] out_hz_r;
  logic [MS_W-1:0] out_ms_r;
  logic            out_rest_r;
  logic            out_last_r;

  logic in_accept;
  logic can_push;
  logic pass_en;
  logic tune_clr;
  logic wn_load;
  logic div_start;
  logic tone_start;
  logic push;
  logic push_last;
  logic stage_set;
  logic note_dot;

  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quo;
  logic [HZ_W-1:0]      tone_hz;
  logic                 tone_busy;
  logic [MS_W-1:0]      ms_val;

  pass_res_t            res;
  note_t                note;
  logic [DIV_DEN_W-1:0] bpm;
  logic                 in_note;

  rtttl_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .pass_en  (pass_en),
    .ch       (char_r),
    .tune_clr (tune_clr),
    .wn_load  (wn_load),
    .wn_val   (div_quo),
    .res      (res),
    .note     (note),
    .bpm      (bpm),
    .in_note  (in_note)
  );

  rtttl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  rtttl_tone u_tone (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (tone_start),
    .index  (note.index),
    .octave (note.octave),
    .rest   (note.rest),
    .hz     (tone_hz),
    .busy   (tone_busy)
  );

  assign in_stall  = (sq_r != SQ_IDLE) || !rst_n;
  assign in_accept = in_valid && !in_stall;
  assign can_push  = !out_valid_r || !out_stall;

  // dotted length is q * 3 / 2, i.e. q + q / 2
  assign ms_val = emit_dot_r ? ({1'b0, div_quo} + {2'b0, div_quo[DIV_NUM_W-1:1]})
                             : {1'b0, div_quo};

  always_comb begin
    sq_nxt     = sq_r;
    pass_en    = 1'b0;
    tune_clr   = 1'b0;
    wn_load    = 1'b0;
    div_start  = 1'b0;
    tone_start = 1'b0;
    div_num    = note.whole_ms;
    div_den    = note.dur;
    push       = 1'b0;
    push_last  = 1'b0;
    stage_set  = 1'b0;
    note_dot   = note.dotted;

    case (sq_r)
      SQ_IDLE: begin
        if (in_accept) sq_nxt = SQ_PASS;
      end
      SQ_PASS: begin
        pass_en = 1'b1;
        if (res.wdiv) begin
          div_start = 1'b1;
          div_num   = WHOLE_NOTE_BASE;
          div_den   = bpm;
          sq_nxt    = SQ_WDIV;
        end else if (res.emit) begin
          div_start  = 1'b1;
          tone_start = 1'b1;
          note_dot   = note.dotted | res.dot_force;
          sq_nxt     = SQ_NDIV;
        end else if (!res.again) begin
          sq_nxt = SQ_END;
        end
      end
      SQ_WDIV: begin
        if (div_done) begin
          wn_load = 1'b1;
          sq_nxt  = SQ_END;
        end
      end
      SQ_NDIV: begin
        if (div_done) begin
          stage_set = 1'b1;
          sq_nxt    = again_r ? SQ_PASS : SQ_END;
        end
      end
      SQ_END: begin
        if (eot_r && in_note) begin
          // the note cut off by the end of text; an earlier result goes first
          if (!stage_v_r || can_push) begin
            push       = stage_v_r;
            div_start  = 1'b1;
            tone_start = 1'b1;
            tune_clr   = 1'b1;
            sq_nxt     = SQ_EDIV;
          end
        end else begin
          tune_clr = eot_r;
          sq_nxt   = SQ_FIN;
        end
      end
      SQ_EDIV: begin
        if (div_done) begin
          stage_set = 1'b1;
          sq_nxt    = SQ_FIN;
        end
      end
      SQ_FIN: begin
        if (!stage_v_r) begin
          sq_nxt = SQ_IDLE;
        end else if (can_push) begin
          push      = 1'b1;
          push_last = 1'b1;
          sq_nxt    = SQ_IDLE;
        end
      end
      default: begin
        sq_nxt = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r        <= SQ_IDLE;
      stage_v_r   <= 1'b0;
      out_valid_r <= 1'b0;
      again_r     <= 1'b0;
    end else begin
      sq_r <= sq_nxt;
      if (pass_en && res.emit) again_r <= res.again;
      if (stage_set) stage_v_r <= 1'b1;
      else if (push) stage_v_r <= 1'b0;
      if (push) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      char_r <= in_text_char;
      eot_r  <= in_end_of_text;
    end
    if (tone_start) begin
      emit_dot_r  <= note_dot;
      emit_rest_r <= note.rest;
    end
    if (stage_set) begin
      stage_hz_r   <= tone_hz;
      stage_ms_r   <= ms_val;
      stage_rest_r <= emit_rest_r;
    end
    if (push) begin
      out_hz_r   <= stage_hz_r;
      out_ms_r   <= stage_ms_r;
      out_rest_r <= stage_rest_r;
      out_last_r <= push_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_tone_hz     = out_hz_r;
  assign out_note_ms     = out_ms_r;
  assign out_is_rest     = out_rest_r;
  assign out_last_of_run = out_last_r;

  // a note ending inside the passes never finds the stage occupied
  `ASSERT_SAME(a_stage_free, (sq_r == SQ_PASS) && res.emit, !stage_v_r, "stage busy at note end")
  // octave scaling must be finished when the length is ready
  `ASSERT_SAME(a_tone_done, div_done && ((sq_r == SQ_NDIV) || (sq_r == SQ_EDIV)), !tone_busy,
    "tone not ready at divide done")
  // an accepted character is parsed in the next cycle
  `ASSERT_NEXT(a_accept_pass, in_accept, sq_r == SQ_PASS, "accepted character not parsed")

endmodule

/* design/rtttl_div.sv */
// ----------------------------------------------------------------------------
// rtttl_div
// restoring divider, one quotient bit per cycle, zero divisor gives zero
// ----------------------------------------------------------------------------
module rtttl_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [rtttl_pkg::DIV_NUM_W-1:0] num,
  input  logic [rtttl_pkg::DIV_DEN_W-1:0] den,
  output logic                           done,
  output logic [rtttl_pkg::DIV_NUM_W-1:0] quo
);
  import rtttl_pkg::*;

  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_NUM_W-1:0] q_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic                 zero_r;

  logic [DIV_DEN_W:0]   sh;
  logic [DIV_DEN_W+1:0] diff;
  logic                 ge;

  // next dividend bit shifts out of the quotient register into the remainder
  assign sh   = {rem_r, q_r[DIV_NUM_W-1]};
  assign diff = {1'b0, sh} - {2'b0, den_r};
  assign ge   = !diff[DIV_DEN_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      q_r    <= num;
      den_r  <= den;
      zero_r <= (den == '0);
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIV_DEN_W-1:0] : sh[DIV_DEN_W-1:0];
      q_r   <= {q_r[DIV_NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = zero_r ? '0 : q_r;

endmodule

/* design/rtttl_tone.sv */
// ----------------------------------------------------------------------------
// rtttl_tone
// pitch lookup and octave scaling, one doubling or halving per cycle
// ----------------------------------------------------------------------------
module rtttl_tone (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [3:0]                index,
  input  logic [3:0]                octave,
  input  logic                      rest,
  output logic [rtttl_pkg::HZ_W-1:0] hz,
  output logic                      busy
);
  import rtttl_pkg::*;

  logic [HZ_W-1:0] hz_r;
  logic [3:0]      cnt_r;
  logic            left_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= (octave > BASE_OCTAVE) ? octave - BASE_OCTAVE : BASE_OCTAVE - octave;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // rests still count the steps, the zero just shifts around
  always_ff @(posedge clk) begin
    if (start) begin
      hz_r   <= rest ? '0 : {{(HZ_W-9){1'b0}}, octave4_hz(index)};
      left_r <= (octave > BASE_OCTAVE);
    end else if (cnt_r != '0) begin
      hz_r <= left_r ? {hz_r[HZ_W-2:0], 1'b0} : {1'b0, hz_r[HZ_W-1:1]};
    end
  end

  assign hz   = hz_r;
  assign busy = (cnt_r != '0);

endmodule

/* design/rtttl_parse.sv */
// ----------------------------------------------------------------------------
// rtttl_parse
// text parser state: one pass over the held character per enabled cycle
// ----------------------------------------------------------------------------
module rtttl_parse (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            pass_en,
  input  logic [7:0]                      ch,
  input  logic                            tune_clr,
  input  logic                            wn_load,
  input  logic [rtttl_pkg::DIV_NUM_W-1:0] wn_val,
  output rtttl_pkg::pass_res_t            res,
  output rtttl_pkg::note_t                note,
  output logic [rtttl_pkg::DIV_DEN_W-1:0] bpm,
  output logic                            in_note
);
  import rtttl_pkg::*;

  typedef enum logic [9:0] {
    PH_NAME     = 10'b0000000001,
    PH_DEF_TOP  = 10'b0000000010,
    PH_DEF_KEY  = 10'b0000000100,
    PH_DEF_NUM  = 10'b0000001000,
    PH_NOTE_TOP = 10'b0000010000,
    PH_NOTE_DUR = 10'b0000100000,
    PH_LETTER   = 10'b0001000000,
    PH_SHARP    = 10'b0010000000,
    PH_DOT      = 10'b0100000000,
    PH_OCTAVE   = 10'b1000000000
  } phase_t;

  typedef enum logic [1:0] {
    KEY_NONE = 2'd0,
    KEY_D    = 2'd1,
    KEY_O    = 2'd2,
    KEY_B    = 2'd3
  } key_t;

  phase_t               phase_r, phase_nxt;
  key_t                 key_r, key_nxt;
  logic [15:0]          acc_r, acc_nxt;
  logic [15:0]          dd_r, dd_nxt;
  logic [3:0]           do_r, do_nxt;
  logic [15:0]          bpm_r, bpm_nxt;
  logic [DIV_NUM_W-1:0] wn_r;
  logic [15:0]          nd_r, nd_nxt;
  logic [3:0]           idx_r, idx_nxt;
  logic                 rest_r, rest_nxt;
  logic                 dot_r, dot_nxt;
  logic [3:0]           oct_r, oct_nxt;

  logic [7:0]  lc;
  logic        store_en;
  logic [15:0] store_v;
  logic        letter_en;
  logic        dig;

  assign lc  = ch | FOLD_CASE;
  assign dig = is_digit(ch);

  always_comb begin
    phase_nxt = phase_r;
    key_nxt   = key_r;
    acc_nxt   = acc_r;
    dd_nxt    = dd_r;
    do_nxt    = do_r;
    bpm_nxt   = bpm_r;
    nd_nxt    = nd_r;
    idx_nxt   = idx_r;
    rest_nxt  = rest_r;
    dot_nxt   = dot_r;
    oct_nxt   = oct_r;
    res       = '0;
    store_en  = 1'b0;
    store_v   = acc_r;
    letter_en = 1'b0;

    case (phase_r)
      PH_NAME: begin
        if (ch == CH_COLON) phase_nxt = PH_DEF_TOP;
      end
      PH_DEF_TOP: begin
        if (ch == CH_COLON) begin
          res.wdiv  = 1'b1;
          phase_nxt = PH_NOTE_TOP;
        end else if (ch == CH_D) begin
          key_nxt   = KEY_D;
          phase_nxt = PH_DEF_KEY;
        end else if (ch == CH_O) begin
          key_nxt   = KEY_O;
          phase_nxt = PH_DEF_KEY;
        end else if (ch == CH_B) begin
          key_nxt   = KEY_B;
          phase_nxt = PH_DEF_KEY;
        end
      end
      PH_DEF_KEY: begin
        if (ch == CH_EQ) begin
          // an empty number already stores zero
          acc_nxt   = '0;
          store_en  = 1'b1;
          store_v   = '0;
          phase_nxt = PH_DEF_NUM;
        end else begin
          key_nxt   = KEY_NONE;
          phase_nxt = PH_DEF_TOP;
          res.again = 1'b1;
        end
      end
      PH_DEF_NUM: begin
        if (dig) begin
          acc_nxt  = sat_acc10(acc_r, ch);
          store_en = 1'b1;
          store_v  = acc_nxt;
        end else begin
          key_nxt   = KEY_NONE;
          phase_nxt = PH_DEF_TOP;
          res.again = 1'b1;
        end
      end
      PH_NOTE_TOP: begin
        if (ch == CH_SPACE || ch == CH_COMMA) begin
          phase_nxt = PH_NOTE_TOP;
        end else if (dig) begin
          nd_nxt    = {12'b0, ch[3:0]};
          phase_nxt = PH_NOTE_DUR;
        end else begin
          nd_nxt    = '0;
          letter_en = 1'b1;
        end
      end
      PH_NOTE_DUR: begin
        if (dig) nd_nxt = sat_acc10(nd_r, ch);
        else letter_en = 1'b1;
      end
      PH_LETTER, PH_SHARP: begin
        if (ch == CH_SHARP && phase_r == PH_LETTER) begin
          if (!rest_r) idx_nxt = idx_r + 1'b1;
          phase_nxt = PH_SHARP;
        end else if (ch == CH_DOT) begin
          dot_nxt   = 1'b1;
          phase_nxt = PH_DOT;
        end else if (dig) begin
          oct_nxt   = ch[3:0];
          phase_nxt = PH_OCTAVE;
        end else begin
          res.emit  = 1'b1;
          res.again = 1'b1;
          phase_nxt = PH_NOTE_TOP;
        end
      end
      PH_DOT: begin
        if (dig) begin
          oct_nxt   = ch[3:0];
          phase_nxt = PH_OCTAVE;
        end else begin
          // a second dot closes the note and is used up
          res.emit  = 1'b1;
          res.again = (ch != CH_DOT);
          phase_nxt = PH_NOTE_TOP;
        end
      end
      PH_OCTAVE: begin
        res.emit  = 1'b1;
        phase_nxt = PH_NOTE_TOP;
        if (ch == CH_DOT) begin
          dot_nxt       = 1'b1;
          res.dot_force = 1'b1;
        end else begin
          res.again = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_NAME;
      end
    endcase

    if (letter_en) begin
      rest_nxt = 1'b0;
      case (lc)
        CH_C:    idx_nxt = 4'd0;
        CH_D:    idx_nxt = 4'd2;
        CH_E:    idx_nxt = 4'd4;
        CH_F:    idx_nxt = 4'd5;
        CH_G:    idx_nxt = 4'd7;
        CH_A:    idx_nxt = 4'd9;
        CH_B:    idx_nxt = 4'd11;
        default: begin
          idx_nxt  = 4'd0;
          rest_nxt = 1'b1;
        end
      endcase
      dot_nxt   = 1'b0;
      oct_nxt   = do_r;
      phase_nxt = PH_LETTER;
    end

    if (store_en) begin
      case (key_r)
        KEY_D:   dd_nxt = store_v;
        KEY_O:   do_nxt = (store_v > 16'd15) ? 4'd15 : store_v[3:0];
        KEY_B:   bpm_nxt = store_v;
        default: dd_nxt = dd_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || tune_clr) begin
      phase_r <= PH_NAME;
      key_r   <= KEY_NONE;
      acc_r   <= '0;
      dd_r    <= RST_DEF_DURATION;
      do_r    <= RST_DEF_OCTAVE;
      bpm_r   <= RST_BPM;
      wn_r    <= '0;
      nd_r    <= '0;
      idx_r   <= '0;
      rest_r  <= 1'b0;
      dot_r   <= 1'b0;
      oct_r   <= RST_DEF_OCTAVE;
    end else begin
      if (pass_en) begin
        phase_r <= phase_nxt;
        key_r   <= key_nxt;
        acc_r   <= acc_nxt;
        dd_r    <= dd_nxt;
        do_r    <= do_nxt;
        bpm_r   <= bpm_nxt;
        nd_r    <= nd_nxt;
        idx_r   <= idx_nxt;
        rest_r  <= rest_nxt;
        dot_r   <= dot_nxt;
        oct_r   <= oct_nxt;
      end
      if (wn_load) wn_r <= wn_val;
    end
  end

  assign note.index    = idx_r;
  assign note.octave   = oct_r;
  assign note.rest     = rest_r;
  assign note.dotted   = dot_r;
  assign note.dur      = (nd_r != '0) ? nd_r : dd_r;
  assign note.whole_ms = wn_r;

  assign bpm     = bpm_r;
  assign in_note = (phase_r == PH_LETTER) || (phase_r == PH_SHARP) ||
                   (phase_r == PH_DOT) || (phase_r == PH_OCTAVE);

endmodule

/* tb/ringtone_text_note_parser_core_tb.sv */
// ----------------------------------------------------------------------------
// ringtone_text_note_parser_core_tb
// self-checking bench for the ringtone text parser: short hand-written tunes
// cover note syntax, the default section, saturation and the value extremes;
// random tunes and character noise follow under random idling on both sides
// and one long result hold-off. every note event is checked against a
// bit-exact parser kept in the bench.
// ----------------------------------------------------------------------------
module ringtone_text_note_parser_core_tb;
  import rtttl_pkg::*;

  typedef enum logic [3:0] {
    PH_NAME, PH_DEF_TOP, PH_DEF_KEY, PH_DEF_NUM, PH_NOTE_TOP,
    PH_NOTE_DUR, PH_LETTER, PH_SHARP, PH_DOT, PH_OCTAVE
  } parse_phase_t;

  typedef enum logic [1:0] {KEY_NONE, KEY_D, KEY_O, KEY_B} default_key_t;

  typedef struct packed {
    logic [HZ_W-1:0] hz;
    logic [MS_W-1:0] ms;
    logic            rest;
    logic            last;
  } note_event_t;

  localparam int unsigned WHOLE_MS_BASE = 240000;
  localparam logic [7:0]  CASE_BIT      = 8'h20;
  localparam int unsigned IDLE_PCT      = 37;
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned RANDOM_CHARS  = 1650;
  localparam int unsigned QUIET_CHARS   = 400;

  logic            clk;
  logic            rst_n          = 1'b0;
  logic            in_valid       = 1'b0;
  logic            in_stall;
  logic [7:0]      in_text_char   = 8'h00;
  logic            in_end_of_text = 1'b0;
  logic            out_valid;
  logic            out_stall      = 1'b0;
  logic [HZ_W-1:0] out_tone_hz;
  logic [MS_W-1:0] out_note_ms;
  logic            out_is_rest;
  logic            out_last_of_run;

  // parser state mirrored in the bench
  parse_phase_t ph;
  default_key_t key;
  logic [15:0]  accum;
  logic [15:0]  dflt_dur;
  logic [3:0]   dflt_oct;
  logic [15:0]  bpm;
  logic [17:0]  whole_ms;
  logic [15:0]  note_dur;
  logic [3:0]   note_idx;
  logic         rest_flag;
  logic         dotted_flag;
  logic [3:0]   note_oct;

  note_event_t note_events_due[$];
  note_event_t char_notes[$];
  logic [7:0]  tune_text[$];

  int unsigned sent_chars     = 0;
  int unsigned parsed_chars   = 0;
  int unsigned notes_checked  = 0;
  int unsigned mismatches     = 0;
  bit          tx_jitter      = 1'b1;
  bit          rx_jitter      = 1'b1;
  bit          hold_request   = 1'b0;
  logic        rx_hold        = 1'b0;

  ringtone_text_note_parser_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_text_char    (in_text_char),
    .in_end_of_text  (in_end_of_text),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_tone_hz     (out_tone_hz),
    .out_note_ms     (out_note_ms),
    .out_is_rest     (out_is_rest),
    .out_last_of_run (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 1000000);
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- parser

  function automatic logic is_num_char(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic [15:0] accum_digit(input logic [15:0] acc, input logic [7:0] c);
    int unsigned v;
    v = acc * 10 + c[3:0];
    return (v > 65535) ? 16'hffff : v[15:0];
  endfunction

  function automatic int unsigned pitch_oct4(input int unsigned i);
    case (i)
      0:       return 262;
      1:       return 277;
      2:       return 294;
      3:       return 311;
      4:       return 330;
      5:       return 349;
      6:       return 370;
      7:       return 392;
      8:       return 415;
      9:       return 440;
      10:      return 466;
      default: return 494;
    endcase
  endfunction

  task automatic reset_parser();
    ph          = PH_NAME;
    key         = KEY_NONE;
    accum       = '0;
    dflt_dur    = 16'd4;
    dflt_oct    = 4'd6;
    bpm         = 16'd63;
    whole_ms    = '0;
    note_dur    = '0;
    note_idx    = '0;
    rest_flag   = 1'b0;
    dotted_flag = 1'b0;
    note_oct    = 4'd6;
  endtask

  task automatic store_default();
    case (key)
      KEY_D:   dflt_dur = accum;
      KEY_O:   dflt_oct = (accum > 16'd15) ? 4'd15 : accum[3:0];
      KEY_B:   bpm = accum;
      default: ;
    endcase
  endtask

  task automatic take_letter(input logic [7:0] c);
    rest_flag = 1'b0;
    case (c | CASE_BIT)
      CH_C:    note_idx = 4'd0;
      CH_D:    note_idx = 4'd2;
      CH_E:    note_idx = 4'd4;
      CH_F:    note_idx = 4'd5;
      CH_G:    note_idx = 4'd7;
      CH_A:    note_idx = 4'd9;
      CH_B:    note_idx = 4'd11;
      default: begin
        note_idx  = 4'd0;
        rest_flag = 1'b1;
      end
    endcase
    dotted_flag = 1'b0;
    note_oct    = dflt_oct;
    ph          = PH_LETTER;
  endtask

  task automatic end_note();
    note_event_t ev;
    int unsigned d, ms, hz;
    d  = (note_dur != 0) ? note_dur : dflt_dur;
    ms = (d != 0) ? whole_ms / d : 0;
    if (dotted_flag) ms = ms * 3 / 2;
    hz = 0;
    if (!rest_flag) begin
      hz = pitch_oct4(note_idx % 12);
      if (note_oct > 4) hz = hz << (note_oct - 4);
      else if (note_oct < 4) hz = hz >> (4 - note_oct);
    end
    ev.hz   = hz[HZ_W-1:0];
    ev.ms   = ms[MS_W-1:0];
    ev.rest = rest_flag;
    ev.last = 1'b0;
    if (char_notes.size() < 2) char_notes.push_back(ev);
  endtask

  // one character through the parser; note events it ends go to the due list
  task automatic parse_ringtone_char(input logic [7:0] c, input logic eot);
    logic        again;
    int unsigned pass, bpm_div;
    char_notes.delete();
    if (ph != PH_NAME || c == CH_COLON) parsed_chars++;
    again = 1'b1;
    for (pass = 0; pass < 3 && again; pass++) begin
      again = 1'b0;
      case (ph)
        PH_NAME: begin
          if (c == CH_COLON) ph = PH_DEF_TOP;
        end
        PH_DEF_TOP: begin
          if (c == CH_COLON) begin
            bpm_div  = (bpm != 0) ? WHOLE_MS_BASE / bpm : 0;
            whole_ms = bpm_div[17:0];
            ph       = PH_NOTE_TOP;
          end else if (c == CH_D) begin
            key = KEY_D;
            ph  = PH_DEF_KEY;
          end else if (c == CH_O) begin
            key = KEY_O;
            ph  = PH_DEF_KEY;
          end else if (c == CH_B) begin
            key = KEY_B;
            ph  = PH_DEF_KEY;
          end
        end
        PH_DEF_KEY: begin
          if (c == CH_EQ) begin
            accum = '0;
            store_default();
            ph = PH_DEF_NUM;
          end else begin
            key   = KEY_NONE;
            ph    = PH_DEF_TOP;
            again = 1'b1;
          end
        end
        PH_DEF_NUM: begin
          if (is_num_char(c)) begin
            accum = accum_digit(accum, c);
            store_default();
          end else begin
            key   = KEY_NONE;
            ph    = PH_DEF_TOP;
            again = 1'b1;
          end
        end
        PH_NOTE_TOP: begin
          if (c == CH_SPACE || c == CH_COMMA) begin
          end else if (is_num_char(c)) begin
            note_dur = {12'd0, c[3:0]};
            ph       = PH_NOTE_DUR;
          end else begin
            note_dur = '0;
            take_letter(c);
          end
        end
        PH_NOTE_DUR: begin
          if (is_num_char(c)) note_dur = accum_digit(note_dur, c);
          else take_letter(c);
        end
        PH_LETTER, PH_SHARP, PH_DOT: begin
          if (ph == PH_LETTER && c == CH_SHARP) begin
            if (!rest_flag) note_idx = note_idx + 4'd1;
            ph = PH_SHARP;
          end else if (ph != PH_DOT && c == CH_DOT) begin
            dotted_flag = 1'b1;
            ph          = PH_DOT;
          end else if (is_num_char(c)) begin
            note_oct = c[3:0];
            ph       = PH_OCTAVE;
          end else if (ph == PH_DOT && c == CH_DOT) begin
            // a second dot closes the note and is used up
            end_note();
            ph = PH_NOTE_TOP;
          end else begin
            end_note();
            ph    = PH_NOTE_TOP;
            again = 1'b1;
          end
        end
        PH_OCTAVE: begin
          if (c == CH_DOT) begin
            dotted_flag = 1'b1;
            end_note();
            ph = PH_NOTE_TOP;
          end else begin
            end_note();
            ph    = PH_NOTE_TOP;
            again = 1'b1;
          end
        end
        default: ph = PH_NAME;
      endcase
    end
    if (eot) begin
      if (ph >= PH_LETTER && ph <= PH_OCTAVE) end_note();
      reset_parser();
    end
    if (char_notes.size() != 0) char_notes[char_notes.size() - 1].last = 1'b1;
    foreach (char_notes[i]) note_events_due.push_back(char_notes[i]);
  endtask

  // ---------------------------------------------------------------- result side

  always @(posedge clk) begin
    out_stall <= rx_hold || (rx_jitter && $urandom_range(99) < IDLE_PCT);
  end

  // long receiver hold-off, counted here
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_note_event
    note_event_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (note_events_due.size() == 0) begin
        $error("note event with none due: hz %0d ms %0d rest %0b last %0b",
               out_tone_hz, out_note_ms, out_is_rest, out_last_of_run);
        mismatches++;
      end else begin
        want = note_events_due.pop_front();
        notes_checked++;
        if (out_tone_hz !== want.hz) begin
          $error("tone_hz: expected %0d, got %0d", want.hz, out_tone_hz);
          mismatches++;
        end
        if (out_note_ms !== want.ms) begin
          $error("note_ms: expected %0d, got %0d", want.ms, out_note_ms);
          mismatches++;
        end
        if (out_is_rest !== want.rest) begin
          $error("is_rest: expected %0b, got %0b", want.rest, out_is_rest);
          mismatches++;
        end
        if (out_last_of_run !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, out_last_of_run);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- input side

  task automatic send_char(input logic [7:0] c, input logic eot);
    if (tx_jitter && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_text_char   <= c;
    in_end_of_text <= eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_chars++;
    parse_ringtone_char(c, eot);
  endtask

  task automatic wait_drained();
    int unsigned k;
    in_valid <= 1'b0;
    k = 0;
    while (note_events_due.size() != 0 && k < DRAIN_LIMIT) begin
      @(posedge clk);
      k++;
    end
    if (note_events_due.size() != 0) begin
      $error("%0d note events never arrived", note_events_due.size());
      mismatches += note_events_due.size();
      note_events_due.delete();
    end
    // a character that ends no note may still be in the divider
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_text(input string s);
    foreach (s[i]) tune_text.push_back(s[i]);
  endtask

  task automatic add_number(input int unsigned v);
    add_text($sformatf("%0d", v));
  endtask

  task automatic add_separator();
    case ($urandom_range(3))
      0:       tune_text.push_back(CH_SPACE);
      1:       add_text(", ");
      default: tune_text.push_back(CH_COMMA);
    endcase
  endtask

  task automatic add_letter();
    string note_letters;
    note_letters = "cdefgabpCDEFGABP";
    if ($urandom_range(15) == 0) tune_text.push_back(8'($urandom_range(255)));
    else tune_text.push_back(note_letters[$urandom_range(15)]);
  endtask

  // the tune's final character carries end of text
  task automatic play_tune();
    foreach (tune_text[i]) send_char(tune_text[i], i == tune_text.size() - 1);
  endtask

  function automatic int unsigned pick_duration();
    int unsigned r;
    r = $urandom_range(19);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(100000, 999999);
    if (r == 2) return $urandom_range(3, 99);
    return 1 << $urandom_range(0, 5);
  endfunction

  function automatic int unsigned pick_bpm();
    int unsigned r;
    r = $urandom_range(19);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(60000, 999999);
    if (r == 2) return 1;
    if (r == 3) return $urandom_range(2, 24);
    return $urandom_range(25, 320);
  endfunction

  function automatic int unsigned pick_octave();
    if ($urandom_range(7) == 0) return $urandom_range(10, 999);
    return $urandom_range(0, 9);
  endfunction

  task automatic build_random_tune();
    logic [7:0] ch;
    tune_text.delete();
    repeat ($urandom_range(0, 4)) begin
      ch = 8'($urandom_range(255));
      if (ch == CH_COLON) ch = CH_SPACE;
      tune_text.push_back(ch);
    end
    tune_text.push_back(CH_COLON);
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          add_text("d=");
          // now and then d= with no digits
          if ($urandom_range(14) != 0) add_number(pick_duration());
        end
        3, 4, 5: begin
          add_text("o=");
          add_number(pick_octave());
        end
        6, 7, 8: begin
          add_text("b=");
          add_number(pick_bpm());
        end
        default: begin
          case ($urandom_range(2))
            0:       tune_text.push_back(CH_D);
            1:       tune_text.push_back(CH_O);
            default: tune_text.push_back(CH_B);
          endcase
          tune_text.push_back(8'($urandom_range(255)));
        end
      endcase
      add_separator();
    end
    if ($urandom_range(19) == 0) return;
    tune_text.push_back(CH_COLON);
    repeat ($urandom_range(1, 7)) begin
      if ($urandom_range(2) == 0) add_number(pick_duration());
      add_letter();
      if ($urandom_range(3) == 0) tune_text.push_back(CH_SHARP);
      if ($urandom_range(3) == 0) tune_text.push_back(CH_DOT);
      if ($urandom_range(1) == 0) tune_text.push_back(8'(CH_0 + $urandom_range(9)));
      if ($urandom_range(5) == 0) tune_text.push_back(CH_DOT);
      if ($urandom_range(5) != 0) add_separator();
    end
    if ($urandom_range(9) == 0) add_number(pick_duration());
  endtask

  // raw bytes and characters from the ringtone alphabet, half of each
  task automatic send_noise();
    string alphabet;
    logic [7:0] ch;
    alphabet = ":=#.,0123456789 dobcpAG";
    repeat ($urandom_range(4, 24)) begin
      if ($urandom_range(1) == 0) ch = 8'($urandom_range(255));
      else ch = alphabet[$urandom_range(alphabet.len() - 1)];
      send_char(ch, $urandom_range(29) == 0);
    end
    if ($urandom_range(1) == 0) send_char(8'($urandom_range(255)), 1'b1);
  endtask

  // ---------------------------------------------------------------- tests

  // sharp, b sharp wrap, octave then dot, low octave, one character ending two notes
  task automatic test_note_syntax();
    tune_text.delete();
    add_text("::b#7.a3G");
    play_tune();
    wait_drained();
  endtask

  // empty d= gives zero length, key with no '=', octave clamp, rest at tune end
  task automatic test_default_section();
    tune_text.delete();
    add_text(":d=,bo=99:c,p");
    play_tune();
    wait_drained();
  endtask

  // bpm saturation, space right after duration digits, octave zero
  task automatic test_number_saturation();
    tune_text.delete();
    add_text(":b=99999:4 e0");
    play_tune();
    wait_drained();
  endtask

  // bpm 1 with a dotted whole note gives the longest duration; nul ends as a rest
  task automatic test_value_extremes();
    tune_text.delete();
    tune_text.push_back(8'hff);
    add_text(":b=1:1f..");
    tune_text.push_back(8'h00);
    play_tune();
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering characters
  task automatic test_result_backpressure();
    tx_jitter    = 1'b0;
    rx_jitter    = 1'b0;
    hold_request = 1'b1;
    repeat (3) begin
      build_random_tune();
      play_tune();
    end
    wait_drained();
    tx_jitter = 1'b1;
    rx_jitter = 1'b1;
  endtask

  task automatic test_random_tunes();
    int unsigned target, quiet_until;
    target      = sent_chars + RANDOM_CHARS;
    quiet_until = sent_chars + QUIET_CHARS;
    tx_jitter   = 1'b0;
    rx_jitter   = 1'b0;
    while (sent_chars < target) begin
      if (sent_chars >= quiet_until) begin
        tx_jitter = 1'b1;
        rx_jitter = 1'b1;
      end
      if ($urandom_range(99) < 85) begin
        build_random_tune();
        play_tune();
      end else begin
        send_noise();
      end
      if ($urandom_range(9) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    reset_parser();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_note_syntax();
    test_default_section();
    test_number_saturation();
    test_value_extremes();
    test_result_backpressure();
    test_random_tunes();

    $display("parsed %0d characters past the tune names, compared %0d note events",
             parsed_chars, notes_checked);
    $display("hand-written tunes, random tunes with noise, idling and a long hold-off");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/rtttl_pkg.sv
design/rtttl_div.sv
design/rtttl_tone.sv
design/rtttl_parse.sv
design/ringtone_text_note_parser_core.sv
tb/ringtone_text_note_parser_core_tb.sv
